// ===== src/pkli_pkg.sv =====
// ----------------------------------------------------------------------------
// Power key and LED idle controller package
// Shared types and constants for the controller and its submodules.
// ----------------------------------------------------------------------------
package pkli_pkg;

    localparam int KEY_W   = 8;
    localparam int TICK_W  = 8;
    localparam int IDLE_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [KEY_W-1:0]  KEY_MAX  = 8'hFF;
    localparam logic [TICK_W-1:0] TICK_MAX = 8'hFF;
    localparam logic [IDLE_W-1:0] IDLE_MAX = 12'hFFF;

    localparam logic [KEY_W-1:0]  HOLD_LIMIT_RST   = 8'd30;
    localparam logic [TICK_W-1:0] BLINK_PERIOD_RST = 8'd10;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST   = 12'd1200;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT   = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  hold_limit;
        logic [TICK_W-1:0] blink_period;
        logic [IDLE_W-1:0] idle_limit;
    } cfg_t;

    typedef struct packed {
        logic power_key;
        logic charging;
        logic connected;
    } item_t;

    typedef struct packed {
        logic red_led;
        logic blue_drive;
        logic white_led;
        logic power_hold;
        logic halted;
    } result_t;

endpackage

// ===== src/pkli_if.sv =====
// ----------------------------------------------------------------------------
// Power key and LED idle controller channels
// Valid/ready channels for tick items, result items and register writes.
// ----------------------------------------------------------------------------
interface pkli_in_if;
    logic valid;
    logic ready;
    logic power_key;
    logic charging;
    logic connected;

    modport source (output valid, output power_key, output charging, output connected,
                    input ready);
    modport sink   (input valid, input power_key, input charging, input connected,
                    output ready);
endinterface

interface pkli_out_if;
    logic valid;
    logic ready;
    logic red_led;
    logic blue_drive;
    logic white_led;
    logic power_hold;
    logic halted;

    modport source (output valid, output red_led, output blue_drive, output white_led,
                    output power_hold, output halted, input ready);
    modport sink   (input valid, input red_led, input blue_drive, input white_led,
                    input power_hold, input halted, output ready);
endinterface

interface pkli_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [11:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/power_key_led_idle_controller.sv =====
// ----------------------------------------------------------------------------
// Power key and LED idle controller
//
//   Channel   Role   Contents
//   in_ch     sink   power_key, charging, connected (one 50 ms tick)
//   out_ch    source red_led, blue_drive, white_led, power_hold, halted
//   cfg_ch    sink   index, data (0 hold limit, 1 blink period, 2 idle limit)
//
// Each tick's result is registered in the result queue and offered from there,
// so one tick can be accepted every cycle while that queue is not full.
// A two-entry result queue sets the limit: input ready drops only when it is full.
// Reset restores the register defaults and clears all counters.
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module power_key_led_idle_controller
(
    input logic       clk,
    input logic       rst_n,
    pkli_in_if.sink   in_ch,
    pkli_out_if.source out_ch,
    pkli_cfg_if.sink  cfg_ch
);
    import pkli_pkg::*;

    cfg_t    cfg;
    item_t   item;
    result_t result;
    result_t out_data;
    logic    full;
    logic    step;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !full;
    assign step         = in_ch.valid && !full;

    assign item.power_key = in_ch.power_key;
    assign item.charging  = in_ch.charging;
    assign item.connected = in_ch.connected;

    pkli_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_ch.valid),
        .wr_index (cfg_ch.index),
        .wr_data  (cfg_ch.data),
        .cfg      (cfg)
    );

    pkli_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    pkli_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (result),
        .full      (full),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.red_led    = out_data.red_led;
    assign out_ch.blue_drive = out_data.blue_drive;
    assign out_ch.white_led  = out_data.white_led;
    assign out_ch.power_hold = out_data.power_hold;
    assign out_ch.halted     = out_data.halted;

endmodule

// ===== src/pkli_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the hold limit, blink period and idle limit written over the port.
// ----------------------------------------------------------------------------
module pkli_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [pkli_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [pkli_pkg::CFG_DATA_W-1:0] wr_data,
    output pkli_pkg::cfg_t                 cfg
);
    import pkli_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_HOLD_LIMIT:   cfg_next.hold_limit   = wr_data[KEY_W-1:0];
                CFG_BLINK_PERIOD: cfg_next.blink_period = wr_data[TICK_W-1:0];
                CFG_IDLE_LIMIT:   cfg_next.idle_limit   = wr_data[IDLE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_limit   <= HOLD_LIMIT_RST;
            cfg_reg.blink_period <= BLINK_PERIOD_RST;
            cfg_reg.idle_limit   <= IDLE_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/pkli_core.sv =====
// ----------------------------------------------------------------------------
// Controller state and tick update
// Holds the counters and LED states and computes one tick's update.
// ----------------------------------------------------------------------------
module pkli_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  pkli_pkg::item_t   item,
    input  pkli_pkg::cfg_t    cfg,
    output pkli_pkg::result_t result
);
    import pkli_pkg::*;

    logic [KEY_W-1:0]  key_cnt_reg, key_cnt_next;
    logic [TICK_W-1:0] tick_cnt_reg, tick_cnt_next, tick_tmp;
    logic [IDLE_W-1:0] idle_cnt_reg, idle_cnt_next, idle_tmp;
    logic phase_reg, phase_next;
    logic red_reg, red_next;
    logic blue_reg, blue_next;
    logic white_reg, white_next;
    logic power_reg, power_next;
    logic halt_reg, halt_next;

    always_comb
    begin
        key_cnt_next  = key_cnt_reg;
        tick_cnt_next = tick_cnt_reg;
        idle_cnt_next = idle_cnt_reg;
        phase_next    = phase_reg;
        red_next      = red_reg;
        blue_next     = blue_reg;
        white_next    = white_reg;
        power_next    = power_reg;
        halt_next     = halt_reg;
        tick_tmp      = tick_cnt_reg;
        idle_tmp      = idle_cnt_reg;

        if (halt_reg || (key_cnt_reg >= cfg.hold_limit))
        begin
            halt_next  = 1'b1;
            blue_next  = 1'b0;
            white_next = 1'b0;
            power_next = 1'b0;
        end
        else
        begin
            if (item.power_key)
            begin
                key_cnt_next = (key_cnt_reg == KEY_MAX) ? KEY_MAX : key_cnt_reg + 1'b1;
            end
            else
            begin
                key_cnt_next = '0;
            end

            red_next = item.charging;

            if (item.connected && !item.charging)
            begin
                blue_next = 1'b1;
                idle_tmp  = '0;
            end
            else if ((tick_cnt_reg >= cfg.blink_period) && !item.charging)
            begin
                phase_next = ~phase_reg;
                blue_next  = ~phase_reg;
                tick_tmp   = '0;
                if (idle_cnt_reg != IDLE_MAX)
                begin
                    idle_tmp = idle_cnt_reg + 1'b1;
                end
            end

            if ((idle_tmp == cfg.idle_limit) && !item.connected)
            begin
                blue_next  = 1'b0;
                white_next = 1'b0;
                power_next = 1'b0;
                idle_tmp   = '0;
            end

            tick_cnt_next = (tick_tmp == TICK_MAX) ? TICK_MAX : tick_tmp + 1'b1;
            idle_cnt_next = idle_tmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cnt_reg  <= '0;
            tick_cnt_reg <= '0;
            idle_cnt_reg <= '0;
            phase_reg    <= 1'b0;
            red_reg      <= 1'b0;
            blue_reg     <= 1'b0;
            white_reg    <= 1'b1;
            power_reg    <= 1'b1;
            halt_reg     <= 1'b0;
        end
        else if (step)
        begin
            key_cnt_reg  <= key_cnt_next;
            tick_cnt_reg <= tick_cnt_next;
            idle_cnt_reg <= idle_cnt_next;
            phase_reg    <= phase_next;
            red_reg      <= red_next;
            blue_reg     <= blue_next;
            white_reg    <= white_next;
            power_reg    <= power_next;
            halt_reg     <= halt_next;
        end
    end

    always_comb
    begin
        result.red_led    = red_next;
        result.blue_drive = blue_next;
        result.white_led  = white_next;
        result.power_hold = power_next;
        result.halted     = halt_next;
    end

endmodule

// ===== src/pkli_obuf.sv =====
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry queue of result registers between the update logic and the output.
// ----------------------------------------------------------------------------
module pkli_obuf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pkli_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output pkli_pkg::result_t out_data
);
    import pkli_pkg::*;

    result_t     mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign pop         = out_valid && out_ready;
    assign full        = (count_reg == 2'd2);
    assign out_valid   = (count_reg != 2'd0);
    assign out_data    = mem[rd_ptr_reg];
    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/pkli_chk.sv =====
// ----------------------------------------------------------------------------
// Controller port checker
// Checks halt, power-off and output stall behaviour seen at the ports.
// ----------------------------------------------------------------------------
module pkli_chk
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic red_led,
    input logic blue_drive,
    input logic white_led,
    input logic power_hold,
    input logic halted
);
    logic seen_halt_reg, seen_halt_next;
    logic seen_off_reg, seen_off_next;
    logic out_fire;

    assign out_fire       = out_valid && out_ready;
    assign seen_halt_next = seen_halt_reg || (out_fire && halted);
    assign seen_off_next  = seen_off_reg || (out_fire && !power_hold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
            seen_off_reg  <= 1'b0;
        end
        else
        begin
            seen_halt_reg <= seen_halt_next;
            seen_off_reg  <= seen_off_next;
        end
    end

    // Once a halted result has been delivered, every later result is halted.
    a_halt_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && seen_halt_reg) |-> halted)
        else $error("result after a halt is not halted");

    // A halted result has power, blue and white off.
    a_halt_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && halted) |-> (!power_hold && !blue_drive && !white_led))
        else $error("halted result drives power or LEDs");

    // Power and white are dropped together and stay off until reset.
    a_power_off_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((white_led == power_hold) && !(seen_off_reg && power_hold)))
        else $error("power or white LED inconsistent after power drop");

    a_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(red_led) && $stable(blue_drive)
            && $stable(white_led) && $stable(power_hold) && $stable(halted)))
        else $error("stalled result changed");

endmodule

bind power_key_led_idle_controller pkli_chk u_pkli_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .red_led    (out_ch.red_led),
    .blue_drive (out_ch.blue_drive),
    .white_led  (out_ch.white_led),
    .power_hold (out_ch.power_hold),
    .halted     (out_ch.halted)
);
